@@ rtl/bsfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

    // Default store depth and largest payload the block can hold.
    localparam int MAX_PAYLOAD_DEF = 256;

    // Field widths.
    localparam int STATUS_W  = 2;
    localparam int PHASE_W   = 3;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 9;
    localparam int COUNT_W   = 16;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd3;

    // Input opcodes.
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD  = 2'd2;

    // Configuration reset values.
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 9'd256;
    localparam logic [BYTE_W-1:0] PREAMBLE_RST   = 8'hAA;
    localparam logic [WORD_W-1:0] SYNC_WORD_RST  = 16'h7E5A;

    // CRC-16/CCITT-FALSE.
    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [LEN_W-1:0]  max_length;
        logic [BYTE_W-1:0] preamble_byte;
        logic [WORD_W-1:0] sync_word;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PHASE_W-1:0]  rx_phase;
        logic [BYTE_W-1:0]   payload_byte;
        logic                payload_last;
        logic [LEN_W-1:0]    payload_length;
        logic [COUNT_W-1:0]  frames_ok;
        logic [COUNT_W-1:0]  crc_error_count;
    } res_t;

    // One byte of the CRC, MSB first, no reflection.
    function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc_in,
                                                     input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bsfr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsfr_core #(
    parameter int MAX_PAYLOAD = bsfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_fire,
    input  wire                 opcode,
    input  wire                 line_bit,
    input  bsfr_pkg::cfg_t      cfg,
    output bsfr_pkg::res_t      res
);
    import bsfr_pkg::*;

    // Lengths above 511 cannot pass the 9-bit limit, so deeper storage is never used.
    localparam int STORE_DEPTH = (MAX_PAYLOAD < 512) ? MAX_PAYLOAD : 512;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LIMIT_CAP   = (MAX_PAYLOAD < 511) ? MAX_PAYLOAD : 511;

    typedef enum logic [PHASE_W-1:0] {
        PH_HUNT = 3'd0,
        PH_SYNC = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAY  = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   window_reg, window_next;
    logic [3:0]          held_reg, held_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [BYTE_W-1:0]   sync_hi_reg, sync_hi_next;
    logic [BYTE_W-1:0]   len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [WORD_W-1:0]   crc_reg, crc_next;
    logic [BYTE_W-1:0]   rx_hi_reg, rx_hi_next;
    logic [LEN_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [COUNT_W-1:0]  good_reg, good_next;
    logic [COUNT_W-1:0]  err_reg, err_next;

    logic [STATUS_W-1:0] r_status_reg, r_status_next;
    logic [PHASE_W-1:0]  r_phase_reg, r_phase_next;
    logic                r_last_reg, r_last_next;
    logic [LEN_W-1:0]    r_len_reg, r_len_next;
    logic                r_read_reg, r_read_next;

    logic [BYTE_W-1:0]   store [STORE_DEPTH];
    logic [BYTE_W-1:0]   rdata_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]   mem_wdata;

    logic [LEN_W-1:0]    limit;
    logic [WORD_W-1:0]   word_in;
    logic [LEN_W:0]      idx_inc, rd_inc;

    assign limit   = (cfg.max_length < LEN_W'(LIMIT_CAP)) ? cfg.max_length : LEN_W'(LIMIT_CAP);
    assign idx_inc = {1'b0, idx_reg} + (LEN_W+1)'(1);
    assign rd_inc  = {1'b0, rd_idx_reg} + (LEN_W+1)'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        window_next   = window_reg;
        held_next     = held_reg;
        idx_next      = idx_reg;
        sync_hi_next  = sync_hi_reg;
        len_hi_next   = len_hi_reg;
        length_next   = length_reg;
        crc_next      = crc_reg;
        rx_hi_next    = rx_hi_reg;
        rd_idx_next   = rd_idx_reg;
        good_next     = good_reg;
        err_next      = err_reg;
        r_status_next = ST_NONE;
        r_last_next   = 1'b0;
        r_read_next   = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = idx_reg[ADDR_W-1:0];
        mem_raddr     = rd_idx_reg[ADDR_W-1:0];
        mem_wdata     = {window_reg[6:0], line_bit};
        word_in       = '0;

        if (opcode == OP_FEED)
        begin
            if (phase_reg == PH_DONE)
            begin
                // A waiting frame ignores the line.
                r_status_next = ST_OK;
            end
            else
            begin
                window_next = {window_reg[6:0], line_bit};
                held_next   = (held_reg < 4'd8) ? held_reg + 4'd1 : held_reg;
                if (held_next == 4'd8)
                begin
                    if (phase_reg == PH_HUNT)
                    begin
                        if (window_next == cfg.preamble_byte)
                        begin
                            phase_next = PH_SYNC;
                            idx_next   = '0;
                            held_next  = '0;
                        end
                    end
                    else
                    begin
                        held_next = '0;
                        unique case (phase_reg)
                            PH_SYNC:
                            begin
                                if (idx_reg == LEN_W'(3))
                                    sync_hi_next = window_next;
                                idx_next = idx_inc[LEN_W-1:0];
                                if (idx_reg == LEN_W'(4))
                                begin
                                    idx_next = '0;
                                    if ({sync_hi_reg, window_next} == cfg.sync_word)
                                        phase_next = PH_LEN;
                                    else
                                        phase_next = PH_HUNT;
                                end
                            end
                            PH_LEN:
                            begin
                                if (idx_reg == '0)
                                begin
                                    len_hi_next = window_next;
                                    idx_next    = LEN_W'(1);
                                end
                                else
                                begin
                                    word_in = {len_hi_reg, window_next};
                                    if (word_in > {7'd0, limit})
                                    begin
                                        r_status_next = ST_BAD_LEN;
                                        phase_next    = PH_HUNT;
                                        window_next   = '0;
                                        held_next     = '0;
                                        idx_next      = '0;
                                        rd_idx_next   = '0;
                                    end
                                    else
                                    begin
                                        idx_next    = '0;
                                        crc_next    = CRC_INIT;
                                        length_next = word_in[LEN_W-1:0];
                                        phase_next  = (word_in != '0) ? PH_PAY : PH_CRC;
                                    end
                                end
                            end
                            PH_PAY:
                            begin
                                mem_we   = ({1'b0, idx_reg} < (LEN_W+1)'(STORE_DEPTH));
                                crc_next = crc16_byte(crc_reg, window_next);
                                idx_next = idx_inc[LEN_W-1:0];
                                if (idx_inc >= {1'b0, length_reg})
                                begin
                                    idx_next   = '0;
                                    phase_next = PH_CRC;
                                end
                            end
                            PH_CRC:
                            begin
                                if (idx_reg == '0)
                                begin
                                    rx_hi_next = window_next;
                                    idx_next   = LEN_W'(1);
                                end
                                else
                                begin
                                    idx_next = '0;
                                    if ({rx_hi_reg, window_next} == crc_reg)
                                    begin
                                        good_next     = good_reg + COUNT_W'(1);
                                        rd_idx_next   = '0;
                                        phase_next    = PH_DONE;
                                        r_status_next = ST_OK;
                                    end
                                    else
                                    begin
                                        err_next      = err_reg + COUNT_W'(1);
                                        r_status_next = ST_CRC_ERR;
                                        phase_next    = PH_HUNT;
                                        window_next   = '0;
                                        held_next     = '0;
                                        rd_idx_next   = '0;
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
        end
        else if (phase_reg == PH_DONE)
        begin
            r_status_next = ST_OK;
            if (length_reg == '0)
            begin
                r_last_next = 1'b1;
            end
            else
            begin
                mem_re      = 1'b1;
                r_read_next = 1'b1;
                rd_idx_next = rd_inc[LEN_W-1:0];
                r_last_next = (rd_inc >= {1'b0, length_reg});
            end
            if (r_last_next)
            begin
                phase_next  = PH_HUNT;
                window_next = '0;
                held_next   = '0;
                idx_next    = '0;
                rd_idx_next = '0;
            end
        end

        r_phase_next = phase_next;
        r_len_next   = '0;
        if ((opcode == OP_FEED && phase_next == PH_DONE) ||
            (opcode == OP_READ && phase_reg == PH_DONE))
            r_len_next = length_reg;
        if (opcode == OP_FEED && phase_next == PH_DONE)
            r_len_next = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            window_reg   <= '0;
            held_reg     <= '0;
            idx_reg      <= '0;
            sync_hi_reg  <= '0;
            len_hi_reg   <= '0;
            length_reg   <= '0;
            crc_reg      <= CRC_INIT;
            rx_hi_reg    <= '0;
            rd_idx_reg   <= '0;
            good_reg     <= '0;
            err_reg      <= '0;
            r_status_reg <= ST_NONE;
            r_phase_reg  <= '0;
            r_last_reg   <= 1'b0;
            r_len_reg    <= '0;
            r_read_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            held_reg     <= held_next;
            idx_reg      <= idx_next;
            sync_hi_reg  <= sync_hi_next;
            len_hi_reg   <= len_hi_next;
            length_reg   <= length_next;
            crc_reg      <= crc_next;
            rx_hi_reg    <= rx_hi_next;
            rd_idx_reg   <= rd_idx_next;
            good_reg     <= good_next;
            err_reg      <= err_next;
            r_status_reg <= r_status_next;
            r_phase_reg  <= r_phase_next;
            r_last_reg   <= r_last_next;
            r_len_reg    <= r_len_next;
            r_read_reg   <= r_read_next;
        end
    end

    // Payload store: one write port, one registered read port. Writes happen only while
    // the payload arrives and reads only once the frame is complete, so the two ports
    // never touch the same entry in one cycle.
    always_ff @(posedge clk)
    begin
        if (in_fire && mem_we)
            store[mem_waddr] <= mem_wdata;
        if (in_fire && mem_re)
            rdata_reg <= store[mem_raddr];
    end

    assign res.status          = r_status_reg;
    assign res.rx_phase        = r_phase_reg;
    assign res.payload_byte    = r_read_reg ? rdata_reg : '0;
    assign res.payload_last    = r_last_reg;
    assign res.payload_length  = r_len_reg;
    assign res.frames_ok       = good_reg;
    assign res.crc_error_count = err_reg;

    a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("payload store read and written in the same cycle");

    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= 4'd8)
        else $error("bit count ran past one byte");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> (rd_idx_reg < length_reg || length_reg == '0))
        else $error("read pointer beyond frame length");

    a_good_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        good_reg != $past(good_reg) |-> r_status_reg == ST_OK && phase_reg == PH_DONE)
        else $error("good frame count moved without a completed frame");

    a_err_only_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != $past(err_reg) |-> r_status_reg == ST_CRC_ERR)
        else $error("error count moved without a CRC mismatch");

endmodule

`default_nettype wire

@@ rtl/bit_stream_frame_receiver_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Serial frame receiver. Each input transaction either feeds one line bit (opcode 0) or
// reads one payload byte of a completed frame (opcode 1), and every input transaction
// yields exactly one output transaction. The receiver hunts for the preamble byte in a
// sliding window of the newest eight bits, then takes five bytes of which the last two
// must equal the sync word, a big-endian 16-bit length that must not exceed the smaller
// of max_length and MAX_PAYLOAD, the payload (kept in an on-chip byte store of
// MAX_PAYLOAD entries, at most 512), and a big-endian CRC-16/CCITT-FALSE that is checked
// against a running CRC computed one byte at a time. A good frame waits until it is
// drained by read transactions; reading the last byte rearms the receiver. The block
// takes one transaction per clock cycle without stalls of its own; each result passes
// through the core's result register, which also holds the store's registered read,
// and then through the output register. While the output is stalled the input takes one
// more transaction and then waits until the output moves again. Configuration writes
// are taken at any time on the cfg channel, but should be made only while the receiver
// is idle.
module bit_stream_frame_receiver_top #(
    parameter int MAX_PAYLOAD = bsfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [0] line_bit, [7:1] zero
    input  wire  [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // [2:0] rx_phase, [10:3] payload_byte,
                                   // [19:11] payload_length, [35:20] frames_ok,
                                   // [51:36] crc_error_count, [55:52] zero
    output logic        m_tlast,   // payload_last
    output logic [1:0]  m_tuser,   // [1:0] status
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import bsfr_pkg::*;

    cfg_t  cfg_reg;
    res_t  core_res;
    res_t  out_res_reg;
    logic  s1_valid_reg;
    logic  out_valid_reg;
    logic  s1_adv;
    logic  in_fire;

    // Configuration registers are always ready; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length    <= MAX_LENGTH_RST;
            cfg_reg.preamble_byte <= PREAMBLE_RST;
            cfg_reg.sync_word     <= SYNC_WORD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_LENGTH: cfg_reg.max_length    <= cfg_data[LEN_W-1:0];
                CFG_PREAMBLE:   cfg_reg.preamble_byte <= cfg_data[BYTE_W-1:0];
                CFG_SYNC_WORD:  cfg_reg.sync_word     <= cfg_data[WORD_W-1:0];
                default:        cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Two result stages: the core's result register and the output register. The core
    // stage moves on whenever the output register is empty or being emptied, so a stalled
    // output still leaves room for one more input transaction.
    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_fire  = s_tvalid && s_tready;

    bsfr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .opcode   (s_tuser[0]),
        .line_bit (s_tdata[0]),
        .cfg      (cfg_reg),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.payload_last;
    assign m_tdata  = {4'd0,
                       out_res_reg.crc_error_count,
                       out_res_reg.frames_ok,
                       out_res_reg.payload_length,
                       out_res_reg.payload_byte,
                       out_res_reg.rx_phase};

endmodule

`default_nettype wire
